[sv/swrr_pkg.sv]
// Shared types and constants for the smooth weighted round-robin picker.
package swrr_pkg;

   // Default sizes of the entry table.
   localparam int DEF_MAX_ENTRIES = 32;
   localparam int DEF_WEIGHT_BITS = 8;

   // Fixed widths of the credits and of the channel fields.
   localparam int CREDIT_BITS = 20;
   localparam int CFG_W       = 6;
   localparam int OP_W        = 2;
   localparam int IDX_PORT_W  = 5;
   localparam int WV_W        = 8;
   localparam int RD_W        = 8;

   // Width used to compare an entry index with a cell position (covers up to 128 cells).
   localparam int IDX_CMP_W = 7;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

   typedef enum logic [OP_W-1:0] {
      OP_PICK  = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

endpackage

[sv/swrr_cell.sv]
// One table entry: weight and credit, with its stage of the pick scan chain.
module swrr_cell #(
   parameter int INDEX       = 0,
   parameter int MAX_ENTRIES = swrr_pkg::DEF_MAX_ENTRIES,
   parameter int WEIGHT_BITS = swrr_pkg::DEF_WEIGHT_BITS,
   parameter int CNT_W       = $clog2(MAX_ENTRIES + 1),
   parameter int IDX_W       = $clog2(MAX_ENTRIES),
   parameter int TOT_W       = WEIGHT_BITS + $clog2(MAX_ENTRIES + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [CNT_W-1:0]                     n_eff,
   input  logic [swrr_pkg::IDX_PORT_W-1:0]      entry_index,
   input  logic                                 set_en,
   input  logic [WEIGHT_BITS-1:0]               set_weight,
   input  logic                                 clear_en,
   input  logic                                 tok_in_valid,
   input  logic                                 tok_in_found,
   input  logic signed [swrr_pkg::CREDIT_BITS-1:0] tok_in_credit,
   input  logic [IDX_W-1:0]                     tok_in_idx,
   input  logic [TOT_W-1:0]                     tok_in_total,
   output logic                                 tok_out_valid,
   output logic                                 tok_out_found,
   output logic signed [swrr_pkg::CREDIT_BITS-1:0] tok_out_credit,
   output logic [IDX_W-1:0]                     tok_out_idx,
   output logic [TOT_W-1:0]                     tok_out_total,
   input  logic                                 sub_en,
   input  logic [IDX_W-1:0]                     sub_idx,
   input  logic [TOT_W-1:0]                     sub_total,
   output logic [WEIGHT_BITS-1:0]               rd_weight
);
   import swrr_pkg::*;

   localparam int SUM_W  = CREDIT_BITS + 1;
   localparam int DIFF_W = ((CREDIT_BITS > TOT_W) ? CREDIT_BITS : TOT_W) + 2;
   localparam logic signed [CREDIT_BITS-1:0] CMAX = CREDIT_BITS'((1 << (CREDIT_BITS - 1)) - 1);
   localparam logic signed [CREDIT_BITS-1:0] CMIN = CREDIT_BITS'(1 << (CREDIT_BITS - 1));
   localparam logic signed [DIFF_W-1:0] DMAX = DIFF_W'((1 << (CREDIT_BITS - 1)) - 1);
   localparam logic signed [DIFF_W-1:0] DMIN = -DMAX - DIFF_W'(1);

   logic [WEIGHT_BITS-1:0]          weight_ff, weight_in;
   logic signed [CREDIT_BITS-1:0]   credit_ff, credit_in;
   logic                            tok_valid_ff, tok_valid_in;
   logic                            tok_found_ff, tok_found_in;
   logic signed [CREDIT_BITS-1:0]   tok_credit_ff, tok_credit_in;
   logic [IDX_W-1:0]                tok_idx_ff, tok_idx_in;
   logic [TOT_W-1:0]                tok_total_ff, tok_total_in;

   logic                            in_use;
   logic                            hit;
   logic                            active;
   logic signed [SUM_W-1:0]         sum;
   logic signed [CREDIT_BITS-1:0]   add_credit;
   logic signed [DIFF_W-1:0]        diff;
   logic signed [CREDIT_BITS-1:0]   sub_credit;
   logic                            better;

   assign in_use = CNT_W'(INDEX) < n_eff;
   assign hit    = IDX_CMP_W'(entry_index) == IDX_CMP_W'(INDEX);
   assign active = in_use && (weight_ff != '0);

   // Adding a weight can only overflow upwards; the two top bits disagree when it does.
   always_comb begin
      sum = {credit_ff[CREDIT_BITS-1], credit_ff} + SUM_W'(weight_ff);
      if (sum[SUM_W-1] != sum[SUM_W-2]) begin
         add_credit = sum[SUM_W-1] ? CMIN : CMAX;
      end else begin
         add_credit = sum[CREDIT_BITS-1:0];
      end
      if (!active) begin
         add_credit = credit_ff;
      end
   end

   always_comb begin
      diff = DIFF_W'(credit_ff) - $signed({1'b0, (DIFF_W - 1)'(sub_total)});
      if (diff > DMAX) begin
         sub_credit = CMAX;
      end else if (diff < DMIN) begin
         sub_credit = CMIN;
      end else begin
         sub_credit = diff[CREDIT_BITS-1:0];
      end
   end

   assign better = !tok_in_found || (add_credit > tok_in_credit);

   always_comb begin
      tok_valid_in  = tok_in_valid;
      tok_found_in  = tok_in_found;
      tok_credit_in = tok_in_credit;
      tok_idx_in    = tok_in_idx;
      tok_total_in  = tok_in_total + (in_use ? TOT_W'(weight_ff) : '0);
      if (active && better) begin
         tok_found_in  = 1'b1;
         tok_credit_in = add_credit;
         tok_idx_in    = IDX_W'(INDEX);
      end
   end

   always_comb begin
      weight_in = weight_ff;
      credit_in = credit_ff;
      if (clear_en) begin
         weight_in = '0;
         credit_in = '0;
      end else if (set_en && hit && in_use) begin
         weight_in = set_weight;
         credit_in = '0;
      end else if (tok_in_valid) begin
         credit_in = add_credit;
      end else if (sub_en && (sub_idx == IDX_W'(INDEX))) begin
         credit_in = sub_credit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff    <= '0;
         credit_ff    <= '0;
         tok_valid_ff <= 1'b0;
      end else begin
         weight_ff    <= weight_in;
         credit_ff    <= credit_in;
         tok_valid_ff <= tok_valid_in;
      end
      tok_found_ff  <= tok_found_in;
      tok_credit_ff <= tok_credit_in;
      tok_idx_ff    <= tok_idx_in;
      tok_total_ff  <= tok_total_in;
   end

   assign tok_out_valid  = tok_valid_ff;
   assign tok_out_found  = tok_found_ff;
   assign tok_out_credit = tok_credit_ff;
   assign tok_out_idx    = tok_idx_ff;
   assign tok_out_total  = tok_total_ff;
   assign rd_weight      = (hit && in_use) ? weight_ff : '0;

endmodule

[sv/smooth_weighted_round_robin_unit.sv]
// Top level of the smooth weighted round-robin picker: controller and row of entry cells.
//
// Requests arrive on the req_ channel (valid/stall) and carry an operation, an entry
// index and a weight; every request gives exactly one item on the rsp_ channel.
// The csr_ port writes the number of entries in use; it must be written only while
// idle, which the block itself does not enforce. A pick launches a scan item into
// the first cell; it moves one cell per cycle along the row, each cell adding its
// weight to its credit and keeping the running best and weight total. When it
// leaves the last cell the winner's credit is reduced by the total. A pick's result
// then goes through the result state into the output register; set weight, clear
// all and read weight go straight to the result state. The next request is accepted
// in the cycle after the result is loaded into the output register.
// Only one request is processed at a time; req_stall is high while one is.
// A result waits in the output register while rsp_stall is high; the block holds it
// and accepts no further request until it has been loaded there.
// Reset clears all weights and credits, sets the in-use count to 32 and empties
// the output register.
module smooth_weighted_round_robin_unit #(
   parameter int MAX_ENTRIES = swrr_pkg::DEF_MAX_ENTRIES,
   parameter int WEIGHT_BITS = swrr_pkg::DEF_WEIGHT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [swrr_pkg::OP_W-1:0]         req_operation,
   input  logic [swrr_pkg::IDX_PORT_W-1:0]   req_entry_index,
   input  logic [swrr_pkg::WV_W-1:0]         req_weight_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_pick_valid,
   output logic [swrr_pkg::IDX_PORT_W-1:0]   rsp_picked_index,
   output logic [swrr_pkg::RD_W-1:0]         rsp_read_weight,
   input  logic                              csr_write_enable,
   input  logic [swrr_pkg::CFG_W-1:0]        csr_write_data
);
   import swrr_pkg::*;

   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W  = $clog2(MAX_ENTRIES);
   localparam int TOT_W  = WEIGHT_BITS + $clog2(MAX_ENTRIES + 1);
   localparam int WEXT_W = (WEIGHT_BITS > WV_W) ? WEIGHT_BITS : WV_W;
   localparam logic [WEXT_W-1:0] WLIM = WEXT_W'((1 << WEIGHT_BITS) - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } state_type;

   state_type                 state_ff;
   logic [CFG_W-1:0]          cfg_ff;
   logic                      pend_pick_ff;
   logic [IDX_PORT_W-1:0]     pend_idx_ff;
   logic [RD_W-1:0]           pend_rd_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_pick_ff;
   logic [IDX_PORT_W-1:0]     rsp_idx_ff;
   logic [RD_W-1:0]           rsp_rd_ff;

   op_type                    op;
   logic                      accept;
   logic [CNT_W-1:0]          n_eff;
   logic [WEXT_W-1:0]         wext;
   logic [WEIGHT_BITS-1:0]    wsat;
   logic [WEIGHT_BITS-1:0]    rd_or;

   logic                      tok_valid  [MAX_ENTRIES+1];
   logic                      tok_found  [MAX_ENTRIES+1];
   logic signed [CREDIT_BITS-1:0] tok_credit [MAX_ENTRIES+1];
   logic [IDX_W-1:0]          tok_idx    [MAX_ENTRIES+1];
   logic [TOT_W-1:0]          tok_total  [MAX_ENTRIES+1];
   logic [WEIGHT_BITS-1:0]    cell_rd    [MAX_ENTRIES];

   logic                      tail_done;
   logic                      sub_en;

   assign op        = op_type'(req_operation);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // An in-use count above the table size acts as the table size.
   assign n_eff = ({1'b0, cfg_ff} > (CFG_W + 1)'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                                : CNT_W'(cfg_ff);

   assign wext = WEXT_W'(req_weight_value);
   assign wsat = (wext > WLIM) ? WEIGHT_BITS'(WLIM) : WEIGHT_BITS'(wext);

   // The scan item enters the first cell in the cycle the pick is accepted.
   assign tok_valid[0]  = accept && (op == OP_PICK);
   assign tok_found[0]  = 1'b0;
   assign tok_credit[0] = '0;
   assign tok_idx[0]    = '0;
   assign tok_total[0]  = '0;

   assign tail_done = tok_valid[MAX_ENTRIES];
   assign sub_en    = tail_done && tok_found[MAX_ENTRIES];

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      swrr_cell #(
         .INDEX       (i),
         .MAX_ENTRIES (MAX_ENTRIES),
         .WEIGHT_BITS (WEIGHT_BITS),
         .CNT_W       (CNT_W),
         .IDX_W       (IDX_W),
         .TOT_W       (TOT_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .n_eff         (n_eff),
         .entry_index   (req_entry_index),
         .set_en        (accept && (op == OP_SET)),
         .set_weight    (wsat),
         .clear_en      (accept && (op == OP_CLEAR)),
         .tok_in_valid  (tok_valid[i]),
         .tok_in_found  (tok_found[i]),
         .tok_in_credit (tok_credit[i]),
         .tok_in_idx    (tok_idx[i]),
         .tok_in_total  (tok_total[i]),
         .tok_out_valid (tok_valid[i+1]),
         .tok_out_found (tok_found[i+1]),
         .tok_out_credit(tok_credit[i+1]),
         .tok_out_idx   (tok_idx[i+1]),
         .tok_out_total (tok_total[i+1]),
         .sub_en        (sub_en),
         .sub_idx       (tok_idx[MAX_ENTRIES]),
         .sub_total     (tok_total[MAX_ENTRIES]),
         .rd_weight     (cell_rd[i])
      );
   end

   // At most one cell matches the read index, so the weights can simply be ORed.
   always_comb begin
      rd_or = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rd_or = rd_or | cell_rd[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            cfg_ff <= csr_write_data;
         end
         // In the result state the output register is either reloaded or still held.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  pend_pick_ff <= 1'b0;
                  pend_idx_ff  <= '0;
                  pend_rd_ff   <= (op == OP_READ) ? RD_W'(rd_or) : '0;
                  state_ff     <= (op == OP_PICK) ? ST_SCAN : ST_RESULT;
               end
            end
            ST_SCAN: begin
               if (tail_done) begin
                  pend_pick_ff <= tok_found[MAX_ENTRIES];
                  pend_idx_ff  <= tok_found[MAX_ENTRIES] ?
                                  IDX_PORT_W'(tok_idx[MAX_ENTRIES]) : '0;
                  state_ff     <= ST_RESULT;
               end
            end
            ST_RESULT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pick_ff  <= pend_pick_ff;
                  rsp_idx_ff   <= pend_idx_ff;
                  rsp_rd_ff    <= pend_rd_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pick_valid   = rsp_pick_ff;
   assign rsp_picked_index = rsp_idx_ff;
   assign rsp_read_weight  = rsp_rd_ff;

endmodule

[verif/smooth_weighted_round_robin_unit_tb.sv]
// Self-checking testbench for the smooth weighted round-robin picker, with its own scheduler model.
module smooth_weighted_round_robin_unit_tb;
   import swrr_pkg::*;

   localparam int MAX_ENTRIES = DEF_MAX_ENTRIES;
   localparam int CREDIT_HI   = (1 <<< (CREDIT_BITS - 1)) - 1;
   localparam int CREDIT_LO   = -(1 <<< (CREDIT_BITS - 1));
   localparam int CHUNKS      = 12;
   localparam int CHUNK_ITEMS = 100;
   localparam int HOLD_CYCLES = 300;

   typedef logic signed [CREDIT_BITS-1:0] credit_type;

   typedef struct packed {
      logic                  pick_valid;
      logic [IDX_PORT_W-1:0] picked_index;
      logic [RD_W-1:0]       read_weight;
   } outcome_type;

   // One row of the directed script: either a request or a write of the in-use count.
   typedef struct packed {
      logic                  is_cfg;
      op_type                op;
      logic [IDX_PORT_W-1:0] idx;
      logic [WV_W-1:0]       wv;
      logic                  typed;
      outcome_type           want;
   } script_row_type;

   localparam outcome_type NOTHING = '{1'b0, 5'd0, 8'd0};

   localparam script_row_type DIRECTED [29] = '{
      '{1'b0, OP_PICK,  5'd0,  8'd0,   1'b1, NOTHING},
      '{1'b0, OP_READ,  5'd31, 8'd0,   1'b1, NOTHING},
      '{1'b0, OP_SET,   5'd0,  8'd255, 1'b1, NOTHING},
      '{1'b0, OP_READ,  5'd0,  8'd0,   1'b1, '{1'b0, 5'd0, 8'd255}},
      '{1'b0, OP_SET,   5'd31, 8'd1,   1'b1, NOTHING},
      '{1'b0, OP_READ,  5'd31, 8'd0,   1'b1, '{1'b0, 5'd0, 8'd1}},
      '{1'b0, OP_SET,   5'd5,  8'd128, 1'b0, NOTHING},
      '{1'b0, OP_PICK,  5'd0,  8'd0,   1'b0, NOTHING},
      '{1'b0, OP_PICK,  5'd31, 8'd255, 1'b0, NOTHING},
      '{1'b0, OP_PICK,  5'd0,  8'd0,   1'b0, NOTHING},
      '{1'b0, OP_SET,   5'd5,  8'd0,   1'b0, NOTHING},
      '{1'b0, OP_PICK,  5'd0,  8'd0,   1'b0, NOTHING},
      '{1'b0, OP_CLEAR, 5'd31, 8'd255, 1'b1, NOTHING},
      '{1'b0, OP_READ,  5'd0,  8'd0,   1'b1, NOTHING},
      '{1'b0, OP_PICK,  5'd0,  8'd0,   1'b1, NOTHING},
      '{1'b0, OP_SET,   5'd3,  8'd3,   1'b0, NOTHING},
      '{1'b0, OP_SET,   5'd7,  8'd3,   1'b0, NOTHING},
      '{1'b0, OP_PICK,  5'd0,  8'd0,   1'b0, NOTHING},
      '{1'b1, OP_PICK,  5'd0,  8'd4,   1'b0, NOTHING},
      '{1'b0, OP_SET,   5'd10, 8'd9,   1'b1, NOTHING},
      '{1'b0, OP_READ,  5'd10, 8'd0,   1'b1, NOTHING},
      '{1'b0, OP_PICK,  5'd0,  8'd0,   1'b0, NOTHING},
      '{1'b1, OP_PICK,  5'd0,  8'd0,   1'b0, NOTHING},
      '{1'b0, OP_PICK,  5'd0,  8'd0,   1'b1, NOTHING},
      '{1'b1, OP_PICK,  5'd0,  8'd63,  1'b0, NOTHING},
      '{1'b0, OP_READ,  5'd10, 8'd0,   1'b1, NOTHING},
      '{1'b0, OP_READ,  5'd7,  8'd0,   1'b1, '{1'b0, 5'd0, 8'd3}},
      '{1'b0, OP_PICK,  5'd0,  8'd0,   1'b0, NOTHING},
      '{1'b1, OP_PICK,  5'd0,  8'd32,  1'b0, NOTHING}
   };

   localparam logic [CFG_W-1:0] CHUNK_IN_USE [CHUNKS] = '{
      6'd32, 6'd1, 6'd7, 6'd0, 6'd63, 6'd33, 6'd16, 6'd2, 6'd32, 6'd5, 6'd31, 6'd32
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OP_W-1:0]       req_operation = '0;
   logic [IDX_PORT_W-1:0] req_entry_index = '0;
   logic [WV_W-1:0]       req_weight_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_pick_valid;
   logic [IDX_PORT_W-1:0] rsp_picked_index;
   logic [RD_W-1:0]       rsp_read_weight;
   logic                  csr_write_enable = 1'b0;
   logic [CFG_W-1:0]      csr_write_data = '0;

   // Scheduler model state.
   logic [WV_W-1:0]  weight_tbl [MAX_ENTRIES] = '{default: '0};
   credit_type       credit_tbl [MAX_ENTRIES] = '{default: '0};
   logic [CFG_W-1:0] in_use_cfg = CFG_RESET;

   outcome_type pending_outcomes [$];
   int send_idle_pct = 33;
   int rcv_idle_pct  = 87;
   int hold_left     = 0;
   int error_count   = 0;
   int results_seen  = 0;
   int entries_picked = 0;
   int settings_used = 0;

   smooth_weighted_round_robin_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_entry_index  (req_entry_index),
      .req_weight_value (req_weight_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pick_valid   (rsp_pick_valid),
      .rsp_picked_index (rsp_picked_index),
      .rsp_read_weight  (rsp_read_weight),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic credit_type clamp_credit(input int value);
      if (value > CREDIT_HI) return credit_type'(CREDIT_HI);
      if (value < CREDIT_LO) return credit_type'(CREDIT_LO);
      return credit_type'(value);
   endfunction

   // Applies one request to the model table and returns the item it should produce.
   function automatic outcome_type schedule_item(input op_type op,
                                                 input logic [IDX_PORT_W-1:0] idx,
                                                 input logic [WV_W-1:0] wv);
      outcome_type res;
      int span;
      int total;
      int best;
      bit found;
      res = NOTHING;
      span = (in_use_cfg > MAX_ENTRIES) ? MAX_ENTRIES : int'(in_use_cfg);
      case (op)
         OP_PICK: begin
            total = 0;
            for (int i = 0; i < span; i++) total += int'(weight_tbl[i]);
            if (total != 0) begin
               found = 1'b0;
               best = 0;
               for (int i = 0; i < span; i++) begin
                  if (weight_tbl[i] != 0) begin
                     credit_tbl[i] = clamp_credit(int'(credit_tbl[i]) + int'(weight_tbl[i]));
                     if (!found || credit_tbl[i] > credit_tbl[best]) begin
                        best = i;
                        found = 1'b1;
                     end
                  end
               end
               credit_tbl[best] = clamp_credit(int'(credit_tbl[best]) - total);
               res.pick_valid = 1'b1;
               res.picked_index = IDX_PORT_W'(best);
            end
         end
         OP_SET: begin
            if (int'(idx) < span) begin
               weight_tbl[idx] = wv;
               credit_tbl[idx] = '0;
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               weight_tbl[i] = '0;
               credit_tbl[i] = '0;
            end
         end
         default: begin
            if (int'(idx) < span) res.read_weight = weight_tbl[idx];
         end
      endcase
      return res;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance with valid
   // still high, so that a following item can be offered without a dip.
   task automatic offer_item(input op_type op, input logic [IDX_PORT_W-1:0] idx,
                             input logic [WV_W-1:0] wv, input bit typed,
                             input outcome_type want);
      outcome_type modelled;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_entry_index <= idx;
      req_weight_value <= wv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      modelled = schedule_item(op, idx, wv);
      pending_outcomes.push_back(typed ? want : modelled);
      @(negedge clock);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
   endtask

   task automatic write_in_use(input logic [CFG_W-1:0] value);
      drain_block();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      in_use_cfg = value;
      settings_used++;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $error("result item arrived with nothing expected");
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            results_seen++;
            if (rsp_pick_valid) entries_picked++;
            if (rsp_pick_valid !== want.pick_valid) begin
               $error("pick_valid: expected %0d, got %0d", want.pick_valid, rsp_pick_valid);
               error_count++;
            end
            if (rsp_picked_index !== want.picked_index) begin
               $error("picked_index: expected %0d, got %0d", want.picked_index, rsp_picked_index);
               error_count++;
            end
            if (rsp_read_weight !== want.read_weight) begin
               $error("read_weight: expected %0d, got %0d", want.read_weight, rsp_read_weight);
               error_count++;
            end
         end
      end
   end

   initial begin
      #4000000;
      $display("smooth_weighted_round_robin_unit_tb: errors");
      $finish;
   end

   initial begin : stimulus
      op_type                op;
      logic [IDX_PORT_W-1:0] idx;
      logic [WV_W-1:0]       wv;
      int                    span;
      int                    roll;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].is_cfg) write_in_use(DIRECTED[r].wv[CFG_W-1:0]);
         else offer_item(DIRECTED[r].op, DIRECTED[r].idx, DIRECTED[r].wv,
                         DIRECTED[r].typed, DIRECTED[r].want);
      end

      for (int c = 0; c < CHUNKS; c++) begin
         write_in_use(CHUNK_IN_USE[c]);
         // First the sender is mostly busy, then the receiver, then neither idles.
         case (c / 4)
            0: begin send_idle_pct = 33; rcv_idle_pct = 87; end
            1: begin send_idle_pct = 87; rcv_idle_pct = 33; end
            default: begin send_idle_pct = 0; rcv_idle_pct = 0; end
         endcase
         if (c == 9) begin
            // Hold the result channel off for a long stretch while requests keep coming.
            @(posedge clock);
            hold_left = HOLD_CYCLES;
            @(negedge clock);
         end
         span = (in_use_cfg > MAX_ENTRIES) ? MAX_ENTRIES : int'(in_use_cfg);
         for (int k = 0; k < CHUNK_ITEMS; k++) begin
            roll = $urandom_range(99);
            if (roll < 48) op = OP_PICK;
            else if (roll < 78) op = OP_SET;
            else if (roll < 97) op = OP_READ;
            else op = OP_CLEAR;
            if (span == 0 || $urandom_range(9) == 0) idx = IDX_PORT_W'($urandom);
            else idx = IDX_PORT_W'($urandom_range(span - 1));
            case ($urandom_range(9))
               0: wv = '0;
               1: wv = '1;
               2, 3: wv = WV_W'($urandom_range(4, 1));
               default: wv = WV_W'($urandom);
            endcase
            offer_item(op, idx, wv, 1'b0, NOTHING);
         end
      end

      drain_block();
      repeat (MAX_ENTRIES + 4) @(posedge clock);
      $display("Checked %0d result items over %0d in-use settings; %0d picks chose an entry.",
               results_seen, settings_used, entries_picked);
      if (error_count == 0) begin
         $display("smooth_weighted_round_robin_unit_tb: clean");
      end else begin
         $display("smooth_weighted_round_robin_unit_tb: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/swrr_pkg.sv
sv/swrr_cell.sv
sv/smooth_weighted_round_robin_unit.sv
verif/smooth_weighted_round_robin_unit_tb.sv
